// ===== rtl/multi_slot_software_timer_defines.svh =====
// assertion macros shared by the timer checker
`ifndef MULTI_SLOT_SOFTWARE_TIMER_DEFINES_SVH
`define MULTI_SLOT_SOFTWARE_TIMER_DEFINES_SVH

// same-cycle implication
`define MST_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MST_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mst_pkg.sv =====
// types and codes shared by the timer table modules
`default_nettype none

package mst_pkg;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ARM    = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_NONE   = 2'd3
  } mst_cmd_e;

  typedef enum logic [2:0] {
    KIND_ARMED     = 3'd0,
    KIND_BUSY      = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_FIRED     = 3'd3,
    KIND_NO_FIRE   = 3'd4
  } mst_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } mst_state_e;

  typedef struct packed {
    mst_cmd_e    op;
    logic [2:0]  slot;
    logic        slot_ok;
    logic [31:0] period;
    logic [31:0] reload;
    logic [31:0] tag;
  } mst_req_t;

endpackage

`default_nettype wire

// ===== rtl/mst_front.sv =====
// request decode: drops unused commands, checks slot range, prepares reload value
`default_nettype none

module mst_front #(
  parameter int SLOT_COUNT = 8
) (
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [2:0]  slot_i,
  input  wire logic [31:0] period_i,
  input  wire logic        repeat_req_i,
  input  wire logic [31:0] tag_i,
  input  wire logic        q_full_i,
  output logic             push_o,
  output mst_pkg::mst_req_t req_o
);
  import mst_pkg::*;

  logic keep;

  always_comb begin
    keep = 1'b1;
    case (cmd_i)
      CMD_TICK:   keep = 1'b1;
      CMD_ARM:    keep = 1'b1;
      CMD_CANCEL: keep = 1'b1;
      default:    keep = 1'b0;
    endcase
  end

  assign in_stall_o     = q_full_i;
  assign push_o         = in_valid_i && !q_full_i && keep;
  assign req_o.op       = mst_cmd_e'(cmd_i);
  assign req_o.slot     = slot_i;
  assign req_o.slot_ok  = (32'(slot_i) < SLOT_COUNT);
  assign req_o.period   = period_i;
  assign req_o.reload   = repeat_req_i ? period_i : 32'd0;
  assign req_o.tag      = tag_i;

endmodule

`default_nettype wire

// ===== rtl/mst_fifo.sv =====
// two-entry request queue between decode and execution
`default_nettype none

module mst_fifo (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  mst_pkg::mst_req_t data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              valid_o,
  output mst_pkg::mst_req_t data_o
);
  import mst_pkg::*;

  mst_req_t   mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = do_push ? !wptr_q : wptr_q;
    rptr_d = do_pop ? !rptr_q : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mst_back.sv =====
// execution: slot table, time counter, serial tick scan and output register
`default_nettype none

module mst_back #(
  parameter int SLOT_COUNT = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [3:0]   cfg_wdata_i,
  input  wire logic         q_valid_i,
  input  mst_pkg::mst_req_t q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [2:0]        kind_o,
  output logic [2:0]        fired_slot_o,
  output logic [31:0]       fired_tag_o,
  output logic              last_o
);
  import mst_pkg::*;

  localparam int NSLOT = (SLOT_COUNT < 8) ? SLOT_COUNT : 8;
  localparam int SW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int IW    = $clog2(NSLOT + 1);

  mst_state_e    state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] limit_q, limit_d;
  logic [3:0]    siu_q;
  logic [31:0]   now_q, now_d;
  logic [NSLOT-1:0] armed_q, armed_d;
  logic [31:0]   due_q    [NSLOT];
  logic [31:0]   reload_q [NSLOT];
  logic [31:0]   tag_q    [NSLOT];

  logic          pend_valid_q, pend_valid_d;
  logic [2:0]    pend_slot_q, pend_slot_d;
  logic [31:0]   pend_tag_q, pend_tag_d;

  logic          out_valid_q;
  mst_kind_e     kind_q;
  logic [2:0]    slot_q;
  logic [31:0]   otag_q;
  logic          last_q;

  logic          out_free;
  logic          emit;
  mst_kind_e     e_kind;
  logic [2:0]    e_slot;
  logic [31:0]   e_tag;
  logic          e_last;
  logic          arm_we;
  logic          scan_we;
  logic [SW-1:0] sidx;
  logic [SW-1:0] ridx;
  logic          hit;
  logic [IW-1:0] lim;

  assign out_free = !out_valid_q || !out_stall_i;
  assign sidx     = idx_q[SW-1:0];
  assign ridx     = q_data_i.slot[SW-1:0];
  assign hit      = armed_q[sidx] && (now_q >= due_q[sidx]);
  assign lim      = (siu_q > 4'(NSLOT)) ? IW'(NSLOT) : IW'(siu_q);

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    limit_d      = limit_q;
    now_d        = now_q;
    armed_d      = armed_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    pend_tag_d   = pend_tag_q;
    q_pop_o      = 1'b0;
    emit         = 1'b0;
    e_kind       = KIND_NO_FIRE;
    e_slot       = 3'd0;
    e_tag        = 32'd0;
    e_last       = 1'b1;
    arm_we       = 1'b0;
    scan_we      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          case (q_data_i.op)
            CMD_ARM: begin
              emit   = 1'b1;
              e_slot = q_data_i.slot;
              if (!q_data_i.slot_ok || armed_q[ridx]) begin
                e_kind = KIND_BUSY;
              end else begin
                e_kind        = KIND_ARMED;
                arm_we        = 1'b1;
                armed_d[ridx] = 1'b1;
              end
            end
            CMD_CANCEL: begin
              emit   = 1'b1;
              e_kind = KIND_CANCELLED;
              e_slot = q_data_i.slot;
              if (q_data_i.slot_ok) begin
                armed_d[ridx] = 1'b0;
              end
            end
            CMD_TICK: begin
              now_d        = now_q + 32'd1;
              idx_d        = '0;
              limit_d      = lim;
              pend_valid_d = 1'b0;
              state_d      = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (idx_q == limit_q) begin
          state_d = ST_DONE;
        end else if (!hit) begin
          idx_d = idx_q + IW'(1);
        end else if (out_free) begin
          if (pend_valid_q) begin
            emit   = 1'b1;
            e_kind = KIND_FIRED;
            e_slot = pend_slot_q;
            e_tag  = pend_tag_q;
            e_last = 1'b0;
          end
          pend_valid_d = 1'b1;
          pend_slot_d  = 3'(idx_q);
          pend_tag_d   = tag_q[sidx];
          if (reload_q[sidx] == 32'd0) begin
            armed_d[sidx] = 1'b0;
          end else begin
            scan_we = 1'b1;
          end
          idx_d = idx_q + IW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
          if (pend_valid_q) begin
            e_kind = KIND_FIRED;
            e_slot = pend_slot_q;
            e_tag  = pend_tag_q;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      limit_q      <= '0;
      siu_q        <= 4'd0;
      now_q        <= 32'd0;
      armed_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      limit_q      <= limit_d;
      now_q        <= now_d;
      armed_q      <= armed_d;
      pend_valid_q <= pend_valid_d;
      if (cfg_we_i) begin
        siu_q <= cfg_wdata_i;
      end
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q <= pend_slot_d;
    pend_tag_q  <= pend_tag_d;
    if (out_free && emit) begin
      kind_q <= e_kind;
      slot_q <= e_slot;
      otag_q <= e_tag;
      last_q <= e_last;
    end
    if (arm_we) begin
      due_q[ridx]    <= now_q + q_data_i.period;
      reload_q[ridx] <= q_data_i.reload;
      tag_q[ridx]    <= q_data_i.tag;
    end else if (scan_we) begin
      due_q[sidx] <= now_q + reload_q[sidx];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign fired_slot_o = slot_q;
  assign fired_tag_o  = otag_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

// ===== rtl/multi_slot_software_timer.sv =====
// timer slot table: top level joining decode, request queue and execution
//
// channel | direction | handshake              | payload
// cfg     | in        | cfg_we_i               | cfg_wdata_i (slots in use)
// in      | in        | in_valid_i / in_stall_o| cmd, slot, period, repeat_req, tag
// out     | out       | out_valid_o/out_stall_i| kind, fired_slot, fired_tag, last
//
// arm and cancel are answered from the idle state once dequeued
// a tick scans min(slots_in_use, SLOT_COUNT, 8) slots, then sends its last result
// one slot compared per cycle by the scan; a firing waits while the output is stalled
// a fired slot is held one step so the last flag marks the final result
// the two-entry queue keeps taking requests while the output register is stalled, until full
// reset clears the time counter, armed bits and slots in use; no clearing pass
`default_nettype none

module multi_slot_software_timer #(
  parameter int SLOT_COUNT = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [2:0]  slot_i,
  input  wire logic [31:0] period_i,
  input  wire logic        repeat_req_i,
  input  wire logic [31:0] tag_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       kind_o,
  output logic [2:0]       fired_slot_o,
  output logic [31:0]      fired_tag_o,
  output logic             last_o
);
  import mst_pkg::*;

  mst_req_t push_req;
  mst_req_t q_req;
  logic     push;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;

  mst_front #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .slot_i      (slot_i),
    .period_i    (period_i),
    .repeat_req_i(repeat_req_i),
    .tag_i       (tag_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .req_o       (push_req)
  );

  mst_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_req),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_req)
  );

  mst_back #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_data_i    (q_req),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .fired_slot_o(fired_slot_o),
    .fired_tag_o (fired_tag_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// ===== rtl/mst_checker.sv =====
// port-level checks on the timer table results, bound to the top level
`default_nettype none

`include "multi_slot_software_timer_defines.svh"

module mst_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  kind_o,
  input wire logic [2:0]  fired_slot_o,
  input wire logic [31:0] fired_tag_o,
  input wire logic        last_o
);
  import mst_pkg::*;

  `MST_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(kind_o) && $stable(fired_tag_o) && $stable(last_o),
    "stalled result changed")

  `MST_ASSERT_NOW(a_kind_legal, clk_i, rst_ni, out_valid_o,
    kind_o == KIND_ARMED || kind_o == KIND_BUSY || kind_o == KIND_CANCELLED ||
    kind_o == KIND_FIRED || kind_o == KIND_NO_FIRE, "illegal result kind")

  `MST_ASSERT_NOW(a_tag_zero, clk_i, rst_ni, out_valid_o && kind_o != KIND_FIRED,
    fired_tag_o == 32'd0, "tag set on non-fire result")

  `MST_ASSERT_NOW(a_no_fire, clk_i, rst_ni, out_valid_o && kind_o == KIND_NO_FIRE,
    last_o && fired_slot_o == 3'd0, "empty tick result malformed")

  `MST_ASSERT_NOW(a_cmd_last, clk_i, rst_ni,
    out_valid_o && (kind_o == KIND_ARMED || kind_o == KIND_BUSY ||
    kind_o == KIND_CANCELLED), last_o, "command answer not marked last")

endmodule

bind multi_slot_software_timer mst_checker u_mst_checker (.*);

`default_nettype wire

// ===== sim/timer_table_checker.sv =====
// timer table checker: tracks slot state, predicts each result and compares in order
module timer_table_checker #(
  parameter int SLOT_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  cmd_i,
  input  logic [2:0]  slot_i,
  input  logic [31:0] period_i,
  input  logic        repeat_req_i,
  input  logic [31:0] tag_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  kind_i,
  input  logic [2:0]  fired_slot_i,
  input  logic [31:0] fired_tag_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import mst_pkg::*;

  typedef struct packed {
    mst_kind_e   kind;
    logic [2:0]  slot;
    logic [31:0] tag;
    logic        last;
  } outcome_t;

  outcome_t    outcome_q[$];
  outcome_t    want;
  logic [31:0] clock_now;
  logic [31:0] due_at[SLOT_COUNT];
  logic [31:0] reload_at[SLOT_COUNT];
  logic        armed_at[SLOT_COUNT];
  logic [31:0] tag_at[SLOT_COUNT];
  logic [3:0]  scan_count;
  int          mismatches;

  task automatic apply_request(mst_cmd_e op, logic [2:0] s, logic [31:0] period,
                               logic rep, logic [31:0] tag);
    int       limit;
    outcome_t held;
    logic     have_held;
    limit = (scan_count > SLOT_COUNT) ? SLOT_COUNT : int'(scan_count);
    if (limit > 8) limit = 8;
    have_held = 1'b0;
    case (op)
      CMD_ARM: begin
        if (s >= SLOT_COUNT || armed_at[s]) begin
          outcome_q.push_back('{KIND_BUSY, s, 32'd0, 1'b1});
        end else begin
          tag_at[s]    = tag;
          reload_at[s] = rep ? period : 32'd0;
          due_at[s]    = clock_now + period;
          armed_at[s]  = 1'b1;
          outcome_q.push_back('{KIND_ARMED, s, 32'd0, 1'b1});
        end
      end
      CMD_CANCEL: begin
        if (s < SLOT_COUNT) armed_at[s] = 1'b0;
        outcome_q.push_back('{KIND_CANCELLED, s, 32'd0, 1'b1});
      end
      CMD_TICK: begin
        clock_now = clock_now + 32'd1;
        for (int i = 0; i < limit; i++) begin
          if (armed_at[i] && clock_now >= due_at[i]) begin
            if (have_held) outcome_q.push_back(held);
            held      = '{KIND_FIRED, 3'(i), tag_at[i], 1'b0};
            have_held = 1'b1;
            if (reload_at[i] == 32'd0) armed_at[i] = 1'b0;
            else due_at[i] = clock_now + reload_at[i];
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          outcome_q.push_back(held);
        end else begin
          outcome_q.push_back('{KIND_NO_FIRE, 3'd0, 32'd0, 1'b1});
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_now  = 32'd0;
      scan_count = 4'd0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        due_at[i]    = 32'd0;
        reload_at[i] = 32'd0;
        armed_at[i]  = 1'b0;
        tag_at[i]    = 32'd0;
      end
      outcome_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind %0d slot %0d tag %h last %0d",
                     kind_i, fired_slot_i, fired_tag_i, last_i);
        end else begin
          want = outcome_q.pop_front();
          if (kind_i !== want.kind || fired_slot_i !== want.slot ||
              fired_tag_i !== want.tag || last_i !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected kind %0d slot %0d tag %h last %0d, got kind %0d slot %0d tag %h last %0d",
                       want.kind, want.slot, want.tag, want.last,
                       kind_i, fired_slot_i, fired_tag_i, last_i);
          end
        end
      end
      if (cfg_we_i) scan_count = cfg_wdata_i;
      if (in_valid_i && !in_stall_i)
        apply_request(mst_cmd_e'(cmd_i), slot_i, period_i, repeat_req_i, tag_i);
      fail_count_o <= mismatches;
      pending_o    <= outcome_q.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// testbench top for the timer table: clock, reset, request stimulus and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mst_pkg::*;

  localparam int IDLE_LIMIT     = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 20;
  localparam int PHASE_REQUESTS = 43;
  localparam int PHASES         = 7;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [3:0]  cfg_wdata_i  = 4'd0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i        = 2'd0;
  logic [2:0]  slot_i       = 3'd0;
  logic [31:0] period_i     = 32'd0;
  logic        repeat_req_i = 1'b0;
  logic [31:0] tag_i        = 32'd0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [2:0]  kind_o;
  logic [2:0]  fired_slot_o;
  logic [31:0] fired_tag_o;
  logic        last_o;

  int   fail_count;
  int   pending;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  logic hold_kick     = 1'b0;
  int   hold_left;
  int   quiet_cycles  = 0;
  int   requests_seen = 0;
  int   results_seen  = 0;
  int   firings_seen  = 0;

  always #1 clk_i = ~clk_i;

  multi_slot_software_timer #(
    .SLOT_COUNT(8)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .slot_i      (slot_i),
    .period_i    (period_i),
    .repeat_req_i(repeat_req_i),
    .tag_i       (tag_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .fired_slot_o(fired_slot_o),
    .fired_tag_o (fired_tag_o),
    .last_o      (last_o)
  );

  timer_table_checker #(
    .SLOT_COUNT(8)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .cmd_i       (cmd_i),
    .slot_i      (slot_i),
    .period_i    (period_i),
    .repeat_req_i(repeat_req_i),
    .tag_i       (tag_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_i      (kind_o),
    .fired_slot_i(fired_slot_o),
    .fired_tag_i (fired_tag_o),
    .last_i      (last_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // result side: random stalls plus a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
    end else if (hold_kick) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (in_valid_i && !in_stall_o) requests_seen <= requests_seen + 1;
    if (out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
      if (kind_o == KIND_FIRED) firings_seen <= firings_seen + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic send_request(mst_cmd_e op, logic [2:0] s, logic [31:0] p, logic rep,
                              logic [31:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= op;
    slot_i       <= s;
    period_i     <= p;
    repeat_req_i <= rep;
    tag_i        <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic random_request(output mst_cmd_e op);
    int          pick;
    int          shape;
    logic [31:0] p;
    pick  = $urandom_range(99);
    shape = $urandom_range(9);
    if (shape < 6) p = $urandom_range(6);
    else if (shape < 8) p = $urandom_range(40);
    else if (shape == 8) p = $urandom;
    else p = 32'hFFFF_FFFF - $urandom_range(3);
    if (pick < 42) op = CMD_TICK;
    else if (pick < 72) op = CMD_ARM;
    else if (pick < 94) op = CMD_CANCEL;
    else op = CMD_NONE;
    send_request(op, 3'($urandom_range(7)), p, 1'($urandom_range(1)), $urandom);
  endtask

  // drain everything outstanding, then leave room for a request with no result
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_slots_in_use(logic [3:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int       settings[PHASES];
    int       done;
    mst_cmd_e op;
    settings = '{8, 0, 3, 8, 1, 6, 2};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // scan range still zero after reset
    send_request(CMD_TICK, 3'd0, 32'd0, 1'b0, 32'd0);
    send_request(CMD_ARM, 3'd2, 32'd0, 1'b0, 32'd0);
    send_request(CMD_TICK, 3'd7, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    set_slots_in_use(4'd8);
    send_request(CMD_TICK, 3'd0, 32'd0, 1'b0, 32'd0);
    send_request(CMD_ARM, 3'd0, 32'd0, 1'b0, 32'hFFFF_FFFF);
    send_request(CMD_ARM, 3'd0, 32'd5, 1'b1, 32'h1111_1111);
    send_request(CMD_ARM, 3'd7, 32'd2, 1'b1, 32'hA5A5_5A5A);
    send_request(CMD_ARM, 3'd3, 32'd0, 1'b1, 32'h5A5A_A5A5);
    repeat (3) send_request(CMD_TICK, 3'd0, 32'd0, 1'b0, 32'd0);
    // due time wraps below now, so it fires on the next tick
    send_request(CMD_ARM, 3'd1, 32'hFFFF_FFFF, 1'b1, 32'h1234_5678);
    send_request(CMD_TICK, 3'd0, 32'd0, 1'b0, 32'd0);
    send_request(CMD_CANCEL, 3'd7, 32'd0, 1'b0, 32'd0);
    send_request(CMD_CANCEL, 3'd7, 32'd0, 1'b0, 32'd0);
    send_request(CMD_CANCEL, 3'd1, 32'd0, 1'b0, 32'd0);
    send_request(CMD_NONE, 3'($urandom_range(7)), $urandom, 1'b1, $urandom);
    for (int s = 0; s < 8; s++)
      send_request(CMD_ARM, 3'(s), 32'd1, 1'b1, $urandom);
    send_request(CMD_TICK, 3'd0, 32'd0, 1'b0, 32'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      set_slots_in_use(4'(settings[ph]));
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 56; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 56; end
        default: begin send_idle_pct = 20; stall_pct <= 20; end
      endcase
      if (ph == 2 || ph == 5) begin
        hold_kick <= 1'b1;
        @(posedge clk_i);
        hold_kick <= 1'b0;
      end
      done = 0;
      while (done < PHASE_REQUESTS) begin
        random_request(op);
        if (op != CMD_NONE) done++;
      end
    end

    settle();
    $display("covered %0d requests and %0d results, %0d of them slot firings, over %0d scan settings",
             requests_seen, results_seen, firings_seen, PHASES + 2);
    if (fail_count == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
